// ===== rtl/core/sct_pkg.sv =====
// Package for the sparse counter table: widths, action codes and a saturating add.
// No dependencies.
package sct_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef logic [31:0]      count_word_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic [3:0] ACT_GET     = 4'd0;
    localparam logic [3:0] ACT_SET     = 4'd1;
    localparam logic [3:0] ACT_SETINC  = 4'd2;
    localparam logic [3:0] ACT_INCR    = 4'd3;
    localparam logic [3:0] ACT_DECR1   = 4'd4;
    localparam logic [3:0] ACT_DECRBY  = 4'd5;
    localparam logic [3:0] ACT_DELETE  = 4'd6;
    localparam logic [3:0] ACT_REINF   = 4'd7;
    localparam logic [3:0] ACT_DECAY   = 4'd8;

    localparam count_word_t ONE       = count_word_t'(1);
    localparam count_word_t COUNT_MAX = 32'hFFFF_FFFF;

    function automatic count_word_t sat_add(input count_word_t a, input count_word_t b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[32] ? COUNT_MAX : s[31:0];
    endfunction

endpackage

// ===== rtl/core/sparse_counter_table.sv =====
// Top level of the sparse counter table: slot memory, fill mark and scan sequencer.
// Depends on sct_pkg.
//
//  channel | dir | fields
//  s_axis  | in  | tdata: action[3:0] key[35:4] value[67:36] amount[99:68]
//  m_axis  | out | tdata: read_value[31:0] found[32] live_entries[43:33] full_error[44]
//
// Every item takes one full scan of the slot memory, then a finish step and an
// output step; the next word is accepted only once the sequencer is back in idle,
// so no word is taken while an earlier one is still being worked on.
// The scan over the one-read-port memory dominates the time per item.
// A slot holds a live entry when it lies below the fill mark and its count is
// nonzero; reset clears the fill mark and the live count, so no clearing pass is needed.
// A result waits in the output register while new words are taken; a later result
// waits in the output step until that register is free.
module sparse_counter_table (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // action, key, value, amount, zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata    // read_value, found, live_entries, full_error, fill
);
    import sct_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // Slot memories; a count of zero marks a free slot.
    count_word_t key_mem [ENTRIES];
    count_word_t val_mem [ENTRIES];
    logic [IDX_W:0] fill_reg;

    logic [1:0]  state_reg;
    logic [IDX_W:0] addr_reg;
    logic        rd_vld_reg;
    idx_t        rd_idx_reg;
    count_word_t rd_key, rd_val;
    logic [3:0]  act_reg;
    count_word_t key_reg, value_reg, amount_reg;
    logic        found_reg, free_seen_reg, err_reg;
    idx_t        hit_idx_reg, free_idx_reg;
    count_word_t hit_val_reg;
    cnt_t        live_reg;
    logic [47:0] out_reg;
    logic        out_vld_reg;

    // Memory write port, driven by the sequencer.
    logic        wr_en;
    idx_t        wr_idx;
    count_word_t wr_key, wr_val;

    always_ff @(posedge clk)
    begin
        rd_key <= key_mem[addr_reg[IDX_W-1:0]];
        rd_val <= val_mem[addr_reg[IDX_W-1:0]];
        if (wr_en)
        begin
            key_mem[wr_idx] <= wr_key;
            val_mem[wr_idx] <= wr_val;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

    logic decaying, hit, rd_live, decay_sel, decay_drop, out_load;
    assign decaying   = (act_reg == ACT_DECAY) || (act_reg == ACT_REINF);
    assign rd_live    = rd_vld_reg && ({1'b0, rd_idx_reg} < fill_reg) && (rd_val != '0);
    assign hit        = rd_live && (rd_key == key_reg);
    assign decay_sel  = rd_live && decaying && !(hit && act_reg == ACT_REINF);
    assign decay_drop = decay_sel && (rd_val <= ONE);
    assign out_load   = (state_reg == ST_OUT) && (!out_vld_reg || m_axis_tready);

    // Decay writes during the scan; the entry being read is never written back
    // elsewhere in the same cycle, so no forwarding is needed. A count that
    // decays to zero frees its slot.
    logic        fin_wr, fin_del, fin_ins;
    count_word_t fin_val;
    always_comb
    begin
        wr_en = 1'b0; wr_idx = rd_idx_reg; wr_key = key_reg; wr_val = rd_val - ONE;
        fin_wr = 1'b0; fin_del = 1'b0; fin_ins = 1'b0; fin_val = hit_val_reg;
        if (state_reg == ST_SCAN && decay_sel)
        begin
            wr_en = 1'b1; wr_key = rd_key;
        end
        if (state_reg == ST_FIN)
        begin
            case (act_reg)
                ACT_SET:
                    if (found_reg)
                        if (value_reg == '0) fin_del = 1'b1;
                        else begin fin_wr = 1'b1; fin_val = value_reg; end
                    else if (value_reg != '0)
                        begin fin_ins = 1'b1; fin_val = value_reg; end
                ACT_SETINC:
                    if (found_reg)
                    begin
                        fin_wr = 1'b1; fin_val = sat_add(hit_val_reg, amount_reg);
                    end
                    else if (value_reg != '0)
                    begin
                        fin_ins = 1'b1; fin_val = value_reg;
                    end
                ACT_INCR, ACT_REINF:
                    if (found_reg)
                    begin
                        fin_wr = 1'b1; fin_val = sat_add(hit_val_reg, ONE);
                    end
                    else
                    begin
                        fin_ins = 1'b1; fin_val = ONE;
                    end
                ACT_DECR1:
                    if (found_reg)
                        if (hit_val_reg <= ONE) fin_del = 1'b1;
                        else begin fin_wr = 1'b1; fin_val = hit_val_reg - ONE; end
                ACT_DECRBY:
                    if (found_reg)
                        if (hit_val_reg <= amount_reg) fin_del = 1'b1;
                        else begin fin_wr = 1'b1; fin_val = hit_val_reg - amount_reg; end
                ACT_DELETE:
                    if (found_reg) fin_del = 1'b1;
                default: ;
            endcase
            if (fin_del)
            begin
                wr_en = 1'b1; wr_idx = hit_idx_reg; wr_val = '0;
            end
            else if (fin_wr)
            begin
                wr_en = 1'b1; wr_idx = hit_idx_reg; wr_val = fin_val;
            end
            else if (fin_ins && free_seen_reg)
            begin
                wr_en = 1'b1; wr_idx = free_idx_reg; wr_val = fin_val;
            end
        end
    end

    // Sequencer: scan all slots, then apply the action and form the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            live_reg    <= '0;
            out_vld_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            addr_reg    <= '0;
        end
        else
        begin
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                out_vld_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        act_reg    <= s_axis_tdata[3:0];
                        key_reg    <= s_axis_tdata[35:4];
                        value_reg  <= s_axis_tdata[67:36];
                        amount_reg <= s_axis_tdata[99:68];
                        found_reg  <= 1'b0;
                        free_seen_reg <= 1'b0;
                        hit_val_reg <= '0;
                        addr_reg   <= '0;
                        rd_vld_reg <= 1'b0;
                        state_reg  <= ST_SCAN;
                    end
                ST_SCAN:
                begin
                    rd_vld_reg <= !addr_reg[IDX_W];
                    rd_idx_reg <= addr_reg[IDX_W-1:0];
                    if (!addr_reg[IDX_W])
                        addr_reg <= addr_reg + 1'b1;
                    if (rd_vld_reg)
                    begin
                        // A decayed key reports its count after the decay.
                        if (hit)
                        begin
                            found_reg   <= 1'b1;
                            hit_idx_reg <= rd_idx_reg;
                            hit_val_reg <= (act_reg == ACT_DECAY) ? rd_val - ONE : rd_val;
                        end
                        if ((!rd_live || decay_drop) && !free_seen_reg)
                        begin
                            free_seen_reg <= 1'b1;
                            free_idx_reg  <= rd_idx_reg;
                        end
                        // Decay: drop entries at one, except the reinforced key.
                        if (decay_drop)
                            live_reg <= live_reg - 1'b1;
                        if (rd_idx_reg == idx_t'(ENTRIES - 1))
                            state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    err_reg <= fin_ins && !free_seen_reg;
                    if (fin_del)
                    begin
                        live_reg <= live_reg - 1'b1;
                        hit_val_reg <= '0;
                    end
                    else if (fin_wr)
                        hit_val_reg <= fin_val;
                    else if (fin_ins && free_seen_reg)
                    begin
                        live_reg <= live_reg + 1'b1;
                        hit_val_reg <= fin_val;
                        if ({1'b0, free_idx_reg} == fill_reg)
                            fill_reg <= fill_reg + 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                default:
                    if (out_load)
                    begin
                        out_reg <= {3'b0, err_reg, 11'(live_reg), found_reg, hit_val_reg};
                        state_reg <= ST_IDLE;
                    end
            endcase
        end
    end

    // Checks on the sequencer.
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= cnt_t'(ENTRIES)) else $error("live count above capacity");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (state_reg == ST_OUT)) else $error("finish step lost");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while waiting");

endmodule
